// ===== rtl/pmprt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmprt_pkg
// Shared types and constants of the protection region table.
// ----------------------------------------------------------------------------
package pmprt_pkg;

    localparam int ENTRY_COUNT = 8;
    localparam int TABLE_DEPTH = 8;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int INDEX_W     = 4;
    localparam int ADDR_W      = 32;
    localparam int CFG_W       = 8;
    localparam int PERM_W      = 8;
    localparam int ENTRY_W     = ADDR_W + CFG_W;

    localparam logic [CFG_W-1:0] MODE_OFF   = 8'h00;
    localparam logic [CFG_W-1:0] MODE_NA4   = 8'h10;
    localparam logic [CFG_W-1:0] MODE_NAPOT = 8'h18;
    localparam logic [CFG_W-1:0] LOCK_BIT   = 8'h80;
    localparam logic [PERM_W-1:0] PERM_MASK = 8'h07;
    localparam logic [ADDR_W-1:0] MIN_SIZE  = 32'd4;

    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_LOCK  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_INDEX  = 2'd1,
        STS_PERM   = 2'd2,
        STS_REGION = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [INDEX_W-1:0] entry_index;
        logic [ADDR_W-1:0]  region_base;
        logic [ADDR_W-1:0]  region_size;
        logic [PERM_W-1:0]  permissions;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CFG_W-1:0]  cfg;
    } entry_t;

endpackage

// ===== rtl/pmprt_ram.sv =====
// ----------------------------------------------------------------------------
// pmprt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pmp_region_table_core.sv =====
// ----------------------------------------------------------------------------
// pmp_region_table_core
// Requests are taken one at a time: each reads its entry from the table RAM
// (registered read), then is checked, encoded and written back while the result
// beat is registered; a stalled output holds the block until the beat is free.
// Reset: all entries read as zero (mode off, unlocked) via per-entry valid
// bits; no clearing pass, the block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
module pmp_region_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[3:0], region_base[35:4], region_size[67:36],
    // permissions[75:68], zero[79:76]
    input  logic [79:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], entry_cfg[9:2], entry_addr[41:10], zero[47:42]
    output logic [47:0] m_tdata
);

    localparam int SW = pmprt_pkg::SLOT_W;

    pmprt_pkg::state_t   state_reg, state_next;
    pmprt_pkg::request_t req_reg, req_in;
    logic [pmprt_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [47:0] m_tdata_reg, m_tdata_next;

    logic                 accept;
    logic                 out_free;
    logic                 finish;
    logic [SW-1:0]        rd_slot;
    logic [SW-1:0]        slot;
    logic [pmprt_pkg::ENTRY_W-1:0] rd_data;
    pmprt_pkg::entry_t    cur_entry, new_entry, res_entry;
    logic                 wr_en;
    logic                 index_bad, perm_bad, region_bad, locked, is_set;
    logic [31:0]          size_m1;
    pmprt_pkg::status_t   status;

    assign req_in.req_type    = pmprt_pkg::req_type_t'(s_tuser);
    assign req_in.entry_index = s_tdata[3:0];
    assign req_in.region_base = s_tdata[35:4];
    assign req_in.region_size = s_tdata[67:36];
    assign req_in.permissions = s_tdata[75:68];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign slot     = req_reg.entry_index[SW-1:0];
    assign rd_slot  = (state_reg == pmprt_pkg::ST_IDLE) ? req_in.entry_index[SW-1:0] : slot;

    pmprt_ram #(
        .WIDTH (pmprt_pkg::ENTRY_W),
        .DEPTH (pmprt_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (new_entry),
        .rd_addr (rd_slot),
        .rd_data (rd_data)
    );

    // invalid entries read as their reset value
    assign cur_entry = valid_reg[slot] ? pmprt_pkg::entry_t'(rd_data) : '0;

    assign index_bad  = req_reg.entry_index >= pmprt_pkg::INDEX_W'(pmprt_pkg::ENTRY_COUNT);
    assign perm_bad   = |(req_reg.permissions & ~pmprt_pkg::PERM_MASK);
    assign size_m1    = req_reg.region_size - 32'd1;
    assign region_bad = (req_reg.region_size < pmprt_pkg::MIN_SIZE)
                        || (|(req_reg.region_size & size_m1))
                        || (|(req_reg.region_base & size_m1));
    assign locked     = |(cur_entry.cfg & pmprt_pkg::LOCK_BIT);
    assign is_set     = (req_reg.req_type == pmprt_pkg::REQ_SET)
                        || (req_reg.req_type == pmprt_pkg::REQ_LOCK);

    always_comb begin
        priority if (index_bad) begin
            status = pmprt_pkg::STS_INDEX;
        end else if (is_set && perm_bad) begin
            status = pmprt_pkg::STS_PERM;
        end else if (is_set && region_bad) begin
            status = pmprt_pkg::STS_REGION;
        end else begin
            status = pmprt_pkg::STS_OK;
        end
    end

    always_comb begin
        new_entry = cur_entry;
        unique case (req_reg.req_type)
            pmprt_pkg::REQ_SET, pmprt_pkg::REQ_LOCK: begin
                if (req_reg.region_size == pmprt_pkg::MIN_SIZE) begin
                    new_entry.addr = {2'b00, req_reg.region_base[31:2]};
                    new_entry.cfg  = req_reg.permissions | pmprt_pkg::MODE_NA4;
                end else begin
                    new_entry.addr = {2'b00, req_reg.region_base[31:2]}
                                     | ({3'b000, req_reg.region_size[31:3]} - 32'd1);
                    new_entry.cfg  = req_reg.permissions | pmprt_pkg::MODE_NAPOT;
                end
                if (req_reg.req_type == pmprt_pkg::REQ_LOCK) begin
                    new_entry.cfg = new_entry.cfg | pmprt_pkg::LOCK_BIT;
                end
            end
            pmprt_pkg::REQ_CLEAR: begin
                new_entry.addr = '0;
                new_entry.cfg  = pmprt_pkg::MODE_OFF;
            end
            pmprt_pkg::REQ_READ: begin
                new_entry = cur_entry;
            end
            default: begin
                new_entry = cur_entry;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pmprt_pkg::ST_IDLE: begin
                if (accept) state_next = pmprt_pkg::ST_EXEC;
            end
            pmprt_pkg::ST_EXEC: begin
                if (out_free) state_next = pmprt_pkg::ST_IDLE;
            end
            default: state_next = pmprt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == pmprt_pkg::ST_IDLE);
        finish        = (state_reg == pmprt_pkg::ST_EXEC) && out_free;
        wr_en         = finish && !index_bad && !locked && (status == pmprt_pkg::STS_OK)
                        && (req_reg.req_type != pmprt_pkg::REQ_READ);
        res_entry     = index_bad ? '0 : (wr_en ? new_entry : cur_entry);
        valid_next    = valid_reg;
        if (wr_en) begin
            valid_next[slot] = 1'b1;
        end
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (finish) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, res_entry.addr, res_entry.cfg, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pmprt_pkg::ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_in;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/pmp_region_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// pmp_region_table_core_tb
// Self-checking bench for the protection region table. A tracker class keeps
// its own copy of the eight entries, predicts status, config byte and encoded
// address for every accepted request beat and checks each result beat in
// order. Directed requests cover the field extremes, every request type,
// locking and the NAPOT-at-base-zero case. Random requests are mostly
// well-formed regions with noise mixed in, under random idling on both sides.
// ----------------------------------------------------------------------------
module pmp_region_table_core_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_COUNT = 1200;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        pmprt_pkg::status_t           status;
        logic [pmprt_pkg::CFG_W-1:0]  cfg;
        logic [pmprt_pkg::ADDR_W-1:0] addr;
    } table_reply_t;

    class pmp_entry_tracker;
        logic [pmprt_pkg::ADDR_W-1:0] addr_copy [pmprt_pkg::TABLE_DEPTH];
        logic [pmprt_pkg::CFG_W-1:0]  cfg_copy  [pmprt_pkg::TABLE_DEPTH];
        table_reply_t                 expected_replies [$];
        int                           mismatches;

        function new();
            for (int i = 0; i < pmprt_pkg::TABLE_DEPTH; i++) begin
                addr_copy[i] = '0;
                cfg_copy[i]  = pmprt_pkg::MODE_OFF;
            end
            mismatches = 0;
        endfunction

        function void note_request(pmprt_pkg::request_t r);
            table_reply_t                 reply;
            int                           slot;
            logic                         locked;
            logic [pmprt_pkg::ADDR_W-1:0] size;
            logic [pmprt_pkg::ADDR_W-1:0] base;
            logic [pmprt_pkg::CFG_W-1:0]  cfg;
            reply.status = pmprt_pkg::STS_OK;
            reply.cfg    = '0;
            reply.addr   = '0;
            if (r.entry_index >= pmprt_pkg::ENTRY_COUNT) begin
                reply.status = pmprt_pkg::STS_INDEX;
                expected_replies.push_back(reply);
                return;
            end
            slot   = int'(r.entry_index);
            locked = (cfg_copy[slot] & pmprt_pkg::LOCK_BIT) != '0;
            size   = r.region_size;
            base   = r.region_base;
            if (r.req_type == pmprt_pkg::REQ_SET || r.req_type == pmprt_pkg::REQ_LOCK) begin
                if ((r.permissions & ~pmprt_pkg::PERM_MASK) != '0)
                    reply.status = pmprt_pkg::STS_PERM;
                else if (size < pmprt_pkg::MIN_SIZE || (size & (size - 1)) != '0
                         || (base & (size - 1)) != '0)
                    reply.status = pmprt_pkg::STS_REGION;
                if (reply.status == pmprt_pkg::STS_OK && !locked) begin
                    cfg = r.permissions;
                    if (size == pmprt_pkg::MIN_SIZE) begin
                        addr_copy[slot] = base >> 2;
                        cfg = cfg | pmprt_pkg::MODE_NA4;
                    end else begin
                        addr_copy[slot] = (base >> 2) | ((size >> 3) - 1);
                        cfg = cfg | pmprt_pkg::MODE_NAPOT;
                    end
                    if (r.req_type == pmprt_pkg::REQ_LOCK) cfg = cfg | pmprt_pkg::LOCK_BIT;
                    cfg_copy[slot] = cfg;
                end
            end else if (r.req_type == pmprt_pkg::REQ_CLEAR && !locked) begin
                cfg_copy[slot]  = pmprt_pkg::MODE_OFF;
                addr_copy[slot] = '0;
            end
            reply.cfg  = cfg_copy[slot];
            reply.addr = addr_copy[slot];
            expected_replies.push_back(reply);
        endfunction

        function void note_failure(string what);
            if (mismatches < 10) $display("mismatch: %s", what);
            mismatches++;
        endfunction

        function void check_reply(logic [47:0] beat);
            table_reply_t                 want;
            pmprt_pkg::status_t           got_status;
            logic [pmprt_pkg::CFG_W-1:0]  got_cfg;
            logic [pmprt_pkg::ADDR_W-1:0] got_addr;
            got_status = pmprt_pkg::status_t'(beat[1:0]);
            got_cfg    = beat[9:2];
            got_addr   = beat[41:10];
            if (expected_replies.size() == 0) begin
                note_failure($sformatf("unexpected beat %h", beat));
                return;
            end
            want = expected_replies.pop_front();
            if (got_status !== want.status || got_cfg !== want.cfg
                || got_addr !== want.addr)
                note_failure($sformatf(
                    "expected status %0d cfg %h addr %h, got %0d %h %h",
                    want.status, want.cfg, want.addr,
                    got_status, got_cfg, got_addr));
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    pmp_entry_tracker tracker = new();
    int               cycle_count  = 0;
    int               replies_seen = 0;
    logic             reply_hold   = 1'b0;

    pmp_region_table_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic pmprt_pkg::request_t make_request(pmprt_pkg::req_type_t kind,
                                                         int idx,
                                                         logic [31:0] base,
                                                         logic [31:0] size,
                                                         logic [7:0] perm);
        pmprt_pkg::request_t r;
        r.req_type    = kind;
        r.entry_index = idx[pmprt_pkg::INDEX_W-1:0];
        r.region_base = base;
        r.region_size = size;
        r.permissions = perm;
        return r;
    endfunction

    function automatic pmprt_pkg::request_t random_request();
        int                  pick;
        int                  k;
        logic [31:0]         size;
        pmprt_pkg::request_t r;
        pick = $urandom_range(0, 99);
        k    = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 12)
                                           : $urandom_range(2, 31);
        size = 32'd1 << k;
        r = make_request(pmprt_pkg::REQ_SET, $urandom_range(0, pmprt_pkg::TABLE_DEPTH - 1),
                         $urandom & ~(size - 1), size, 8'($urandom_range(0, 7)));
        if (pick < 45) begin
            r.req_type = pmprt_pkg::REQ_SET;
        end else if (pick < 47) begin
            // lock well-formed regions only on the top two entries
            r.req_type    = pmprt_pkg::REQ_LOCK;
            r.entry_index = pmprt_pkg::INDEX_W'($urandom_range(pmprt_pkg::TABLE_DEPTH - 2,
                                                               pmprt_pkg::TABLE_DEPTH - 1));
        end else if (pick < 62) begin
            r.req_type    = pmprt_pkg::REQ_CLEAR;
            r.region_base = $urandom;
            r.region_size = $urandom;
            r.permissions = 8'($urandom);
        end else if (pick < 82) begin
            r.req_type    = pmprt_pkg::REQ_READ;
            r.region_base = $urandom;
            r.region_size = $urandom;
            r.permissions = 8'($urandom);
        end else begin
            r.req_type    = pmprt_pkg::req_type_t'($urandom_range(0, 3));
            r.entry_index = pmprt_pkg::INDEX_W'($urandom_range(0, 15));
            r.permissions = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0: begin
                    r.region_size = $urandom;
                    r.region_base = $urandom;
                end
                1: r.region_base = $urandom;
                default: r.region_size = size | (32'd1 << $urandom_range(0, 31));
            endcase
            // keep stray locks from sealing the lower entries
            if (r.req_type == pmprt_pkg::REQ_LOCK && r.entry_index < pmprt_pkg::ENTRY_COUNT)
                r.permissions = r.permissions | 8'h08;
        end
        return r;
    endfunction

    task automatic send_request(pmprt_pkg::request_t r, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'b0, r.permissions, r.region_size, r.region_base,
                     r.entry_index};
        s_tuser  <= r.req_type;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(r);
    endtask

    task automatic collect_replies();
        int stall;
        bit eager;
        eager = 1'b0;
        forever begin
            if (replies_seen % 40 == 0) eager = ($urandom_range(0, 3) == 0);
            stall = eager ? 0 : $urandom_range(0, 15);
            if (replies_seen == 100 && !reply_hold) begin
                reply_hold = 1'b1;
                stall      = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            reply_hold = 1'b0;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_reply(m_tdata);
            replies_seen++;
        end
    endtask

    initial begin
        pmprt_pkg::request_t directed [$];
        int                  gap;
        bit                  eager;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            collect_replies();
        join_none

        directed.push_back(make_request(pmprt_pkg::REQ_READ,  0, 32'h0, 32'h0, 8'h00));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   0, 32'h0, 32'd4, 8'h07));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   1, 32'h0, 32'd8, 8'h01));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   2, 32'h8000_0000,
                                        32'h8000_0000, 8'h05));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   3, 32'hFFFF_FFFC,
                                        32'd4, 8'h00));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   4, 32'h0, 32'd0, 8'h01));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   4, 32'h0, 32'd2, 8'h01));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   4, 32'h0,
                                        32'hFFFF_FFFF, 8'h02));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   4, 32'h10, 32'h20, 8'h03));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   4, 32'h3, 32'd0, 8'hFF));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,  15, 32'h3, 32'd0, 8'hFF));
        directed.push_back(make_request(pmprt_pkg::REQ_READ,  8, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 8'hFF));
        directed.push_back(make_request(pmprt_pkg::REQ_CLEAR, 9, 32'h0, 32'h0, 8'h00));
        directed.push_back(make_request(pmprt_pkg::REQ_CLEAR, 0, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 8'hFF));
        directed.push_back(make_request(pmprt_pkg::REQ_READ,  2, 32'h0, 32'h0, 8'h00));
        directed.push_back(make_request(pmprt_pkg::REQ_LOCK,  7, 32'h1000, 32'h1000,
                                        8'h03));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   7, 32'h0, 32'd4, 8'h07));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   7, 32'h0, 32'd4, 8'h80));
        directed.push_back(make_request(pmprt_pkg::REQ_CLEAR, 7, 32'h0, 32'h0, 8'h00));
        directed.push_back(make_request(pmprt_pkg::REQ_READ,  7, 32'h0, 32'h0, 8'h00));
        directed.push_back(make_request(pmprt_pkg::REQ_LOCK,  5, 32'h0, 32'd12, 8'h01));
        directed.push_back(make_request(pmprt_pkg::REQ_SET,   5, 32'h30, 32'h10, 8'h04));
        directed.push_back(make_request(pmprt_pkg::REQ_LOCK, 12, 32'h0, 32'd4, 8'h01));
        directed.push_back(make_request(pmprt_pkg::REQ_READ,  5, 32'h0, 32'h0, 8'h00));

        foreach (directed[i]) send_request(directed[i], $urandom_range(0, 3));

        eager = 1'b0;
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n % 40 == 0) eager = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_COUNT / 2) begin
                s_tvalid <= 1'b0;
                while (tracker.pending() > 0) @(posedge aclk);
            end
            gap = (eager || reply_hold) ? 0 : $urandom_range(0, 15);
            send_request(random_request(), gap);
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
